### src/tiled_pixmap_line_blit_1bpp_macros.svh
// Assertion macros used by the checker of the line blitter
`ifndef TILED_PIXMAP_LINE_BLIT_1BPP_MACROS_SVH
`define TILED_PIXMAP_LINE_BLIT_1BPP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TPLB_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define TPLB_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tplb_pkg.sv
// Shared types and constants of the tiled pixelmap line blitter
`timescale 1ns / 1ps
`default_nettype none

package tplb_pkg;

  // Request kinds carried in the input tuser
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_DRAW   = 2'd1;
  localparam logic [1:0] REQ_REWIND = 2'd2;

  // Pixel formats
  localparam logic [1:0] MODE_RAW   = 2'd0;
  localparam logic [1:0] MODE_RAW_T = 2'd1;
  localparam logic [1:0] MODE_RLE   = 2'd2;
  localparam logic [1:0] MODE_RLE_T = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_WIDTH  = 3'd1;
  localparam logic [2:0] REG_BYTES  = 3'd2;
  localparam logic [2:0] REG_PITCH  = 3'd3;
  localparam logic [2:0] REG_OFFSET = 3'd4;

  // Line limits
  localparam int MAX_LINE_PIXELS = 480;
  localparam int MAX_RESULTS     = 61;
  localparam int LB              = MAX_RESULTS * 8;
  localparam int LBW             = $clog2(LB);
  // Signed pixel column and byte pointer widths
  localparam int XW = 16;
  localparam int GW = 15;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic load;
    logic rewind;
    logic mod_step;
    logic setup;
    logic raw_issue;
    logic hdr_issue;
    logic dec;
    logic run_step;
    logic lit_step;
    logic tile_next;
    logic finish;
    logic out_shift;
  } tplb_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic mod_last;
    logic raw_last;
    logic dec_run;
    logic lit_one;
    logic grp_last;
    logic row_end;
    logic tile_more;
    logic drawing;
    logic rle;
    logic out_last;
  } tplb_sts_t;

endpackage

`default_nettype wire

### src/tplb_regs.sv
// Configuration register file with its APB-style access port
`timescale 1ns / 1ps
`default_nettype none

module tplb_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  output logic      [1:0]  mode,
  output logic      [12:0] pixmap_width,
  output logic      [12:0] pixmap_bytes,
  output logic      [8:0]  line_pitch,
  output logic      [11:0] tile_offset
);

  logic [1:0]  mode_r;
  logic [12:0] width_r;
  logic [12:0] bytes_r;
  logic [8:0]  pitch_r;
  logic [11:0] offset_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[4:2];

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 2'd0;
      width_r  <= 13'd1;
      bytes_r  <= 13'd1;
      pitch_r  <= 9'd480;
      offset_r <= 12'd0;
    end else if (wr_en) begin
      unique case (reg_idx)
        tplb_pkg::REG_MODE:   mode_r   <= cfg_pwdata[1:0];
        tplb_pkg::REG_WIDTH:  width_r  <= cfg_pwdata[12:0];
        tplb_pkg::REG_BYTES:  bytes_r  <= cfg_pwdata[12:0];
        tplb_pkg::REG_PITCH:  pitch_r  <= cfg_pwdata[8:0];
        tplb_pkg::REG_OFFSET: offset_r <= cfg_pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (reg_idx)
      tplb_pkg::REG_MODE:   cfg_prdata = {30'd0, mode_r};
      tplb_pkg::REG_WIDTH:  cfg_prdata = {19'd0, width_r};
      tplb_pkg::REG_BYTES:  cfg_prdata = {19'd0, bytes_r};
      tplb_pkg::REG_PITCH:  cfg_prdata = {23'd0, pitch_r};
      tplb_pkg::REG_OFFSET: cfg_prdata = {20'd0, offset_r};
      default:              cfg_prdata = 32'd0;
    endcase
  end

  assign mode         = mode_r;
  assign pixmap_width = width_r;
  assign pixmap_bytes = bytes_r;
  assign line_pitch   = pitch_r;
  assign tile_offset  = offset_r;

endmodule

`default_nettype wire

### src/tplb_ctrl.sv
// Controller state machine that sequences one request at a time
`timescale 1ns / 1ps
`default_nettype none

module tplb_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  input  wire logic [1:0]          req_type,
  output logic                     in_tready,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  input  wire tplb_pkg::tplb_sts_t sts,
  output tplb_pkg::tplb_cmd_t      cmd
);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_MOD    = 11'b000_0000_0010,
    ST_SETUP  = 11'b000_0000_0100,
    ST_RAW    = 11'b000_0000_1000,
    ST_HDR    = 11'b000_0001_0000,
    ST_DEC    = 11'b000_0010_0000,
    ST_RUN    = 11'b000_0100_0000,
    ST_LIT    = 11'b000_1000_0000,
    ST_TILE   = 11'b001_0000_0000,
    ST_DRAIN  = 11'b010_0000_0000,
    ST_OUT    = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Advance the sequence and issue datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          unique case (req_type)
            tplb_pkg::REQ_LOAD:   cmd.load = 1'b1;
            tplb_pkg::REQ_REWIND: cmd.rewind = 1'b1;
            tplb_pkg::REQ_DRAW: begin
              cmd.capture = 1'b1;
              state_nxt   = ST_MOD;
            end
            default: ;
          endcase
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        if (sts.rle)          state_nxt = ST_HDR;
        else if (sts.drawing) state_nxt = ST_RAW;
        else                  state_nxt = ST_DRAIN;
      end
      ST_RAW: begin
        cmd.raw_issue = 1'b1;
        if (sts.raw_last) state_nxt = ST_DRAIN;
      end
      ST_HDR: begin
        cmd.hdr_issue = 1'b1;
        state_nxt     = ST_DEC;
      end
      ST_DEC: begin
        cmd.dec = 1'b1;
        if (sts.dec_run)      state_nxt = ST_RUN;
        else if (!sts.lit_one) state_nxt = ST_LIT;
        else if (sts.row_end) state_nxt = ST_TILE;
        else                  state_nxt = ST_HDR;
      end
      ST_RUN: begin
        cmd.run_step = 1'b1;
        if (sts.grp_last) state_nxt = sts.row_end ? ST_TILE : ST_HDR;
      end
      ST_LIT: begin
        cmd.lit_step = 1'b1;
        if (sts.grp_last) state_nxt = sts.row_end ? ST_TILE : ST_HDR;
      end
      ST_TILE: begin
        if (sts.tile_more) begin
          cmd.tile_next = 1'b1;
          state_nxt     = ST_HDR;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.finish = 1'b1;
        state_nxt  = sts.drawing ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (out_tready) begin
          cmd.out_shift = 1'b1;
          if (sts.out_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### src/tplb_dp.sv
// Datapath: pixelmap store, tile walker, run-length decoder and line buffer
`timescale 1ns / 1ps
`default_nettype none

module tplb_dp #(
  parameter int STORE_BYTES = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [1:0]          mode,
  input  wire logic [12:0]         pixmap_width,
  input  wire logic [12:0]         pixmap_bytes,
  input  wire logic [8:0]          line_pitch,
  input  wire logic [11:0]         tile_offset,
  input  wire logic [11:0]         load_addr,
  input  wire logic [7:0]          load_byte,
  input  wire logic [8:0]          x_first,
  input  wire logic [8:0]          x_last,
  input  wire logic [9:0]          row_y,
  input  wire logic                draw_enable,
  input  wire tplb_pkg::tplb_cmd_t cmd,
  output tplb_pkg::tplb_sts_t      sts,
  output logic [15:0]              fb_index,
  output logic [7:0]               fb_data,
  output logic [7:0]               fb_mask,
  output logic                     fb_last
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int XW = tplb_pkg::XW;
  localparam int GW = tplb_pkg::GW;
  localparam int LB = tplb_pkg::LB;

  // Pixelmap store and its registered read
  logic [7:0]    store_r [STORE_BYTES];
  logic [7:0]    mem_q_r;
  logic [GW-1:0] rd_addr;

  // Request fields held for the whole line
  logic [8:0]  xf_r, xl_r;
  logic        drawing_r;
  logic [15:0] base_idx_r;
  logic [5:0]  lastk_r, kout_r;
  logic [12:0] rp_r;

  // Offset remainder unit
  logic [12:0] rem_r, rem_nxt;
  logic [3:0]  mcnt_r;
  logic [13:0] rem_t;

  // Walker state
  logic signed [XW-1:0] x_r, te_r, px_r;
  logic [12:0]          o_r;
  logic [2:0]           psub_r;
  logic                 pv_r;
  logic [GW-1:0]        g_r;
  logic [6:0]           cnt_r;
  logic [7:0]           hdr_r;

  // Line buffer, pixel bit 0 is the leftmost of the first byte
  logic [LB-1:0] dvec_r, mvec_r;

  logic [12:0]          w;
  logic signed [XW-1:0] w_s, xf_s, xl_s, base8_s, x_setup;
  logic [9:0]           lim;
  logic [8:0]           xl_a, xl_c;
  logic [6:0]           stride;
  logic [16:0]          prod;
  logic                 rle;
  logic [GW-1:0]        addr_raw, next_ptr;
  logic [13:0]          o_inc;
  logic [13:0]          raw_bytes;
  logic [6:0]           dec_n;

  // Pixel put
  logic                 put_en, op, val, in_span, hit;
  logic [7:0]           pbyte;
  logic [2:0]           psub;
  logic signed [XW-1:0] pxx;
  logic [tplb_pkg::LBW-1:0] pidx;
  logic [LB-1:0]        pbit;

  assign w       = (pixmap_width == 13'd0) ? 13'd1 : pixmap_width;
  assign w_s     = $signed({{(XW-13){1'b0}}, w});
  assign xf_s    = $signed({{(XW-9){1'b0}}, xf_r});
  assign xl_s    = $signed({{(XW-9){1'b0}}, xl_r});
  assign base8_s = $signed({{(XW-9){1'b0}}, xf_r[8:3], 3'b000});
  assign rle     = mode[1];

  // Clamp the span and form the frame byte base
  assign lim    = {1'b0, x_first[8:3], 3'b000} + 10'(LB - 1);
  assign xl_a   = (x_last > 9'(tplb_pkg::MAX_LINE_PIXELS - 1)) ?
                  9'(tplb_pkg::MAX_LINE_PIXELS - 1) : x_last;
  assign xl_c   = ({1'b0, xl_a} > lim) ? lim[8:0] : xl_a;
  assign stride = 7'(({1'b0, line_pitch} + 10'd7) >> 3);
  assign prod   = 17'(row_y) * 17'(stride);

  // One remainder bit per step
  assign rem_t   = {rem_r, tile_offset[4'd11 - mcnt_r]};
  assign rem_nxt = (rem_t >= {1'b0, w}) ? 13'(rem_t - {1'b0, w}) : rem_t[12:0];

  // Raw modes start at the first span pixel; run-length starts at the tile origin
  assign x_setup  = !rle ? xf_s :
                    (drawing_r ? (xf_s - $signed({{(XW-13){1'b0}}, rem_r})) : '0);
  assign addr_raw = GW'(rp_r) + ((mode == tplb_pkg::MODE_RAW) ? GW'(o_r[12:3]) :
                                                                 GW'(o_r[12:2]));
  assign o_inc    = {1'b0, o_r} + 14'd1;
  assign rd_addr  = cmd.raw_issue ? addr_raw : g_r;
  assign dec_n    = 7'(mem_q_r[6:0] >> ((mode == tplb_pkg::MODE_RLE) ? 1 : 2)) + 7'd1;

  assign raw_bytes = (mode == tplb_pkg::MODE_RAW) ? ((14'(w) + 14'd7) >> 3) :
                                                    ((14'(w) + 14'd3) >> 2);
  assign next_ptr  = rle ? g_r : (GW'(rp_r) + GW'(raw_bytes));

  // Store write and read
  always_ff @(posedge clk) begin
    if (cmd.load) store_r[AW'(load_addr)] <= load_byte;
    mem_q_r <= store_r[AW'(rd_addr)];
  end

  // Select the pixel source: a returning read, or the byte at hand
  always_comb begin
    put_en = pv_r | cmd.run_step | (cmd.dec & ~mem_q_r[7]);
    pbyte  = (cmd.run_step && !pv_r) ? hdr_r : mem_q_r;
    psub   = pv_r ? psub_r : 3'd0;
    pxx    = pv_r ? px_r : x_r;
    case (mode)
      tplb_pkg::MODE_RAW: begin
        op  = 1'b1;
        val = pbyte[3'd7 - psub];
      end
      tplb_pkg::MODE_RAW_T: begin
        op  = pbyte[3'd6 - {psub[1:0], 1'b0}];
        val = pbyte[3'd7 - {psub[1:0], 1'b0}];
      end
      tplb_pkg::MODE_RLE: begin
        op  = 1'b1;
        val = pbyte[0];
      end
      default: begin
        op  = pbyte[0];
        val = pbyte[1];
      end
    endcase
    in_span = (pxx >= xf_s) && (pxx <= xl_s);
    hit     = put_en && drawing_r && in_span && op;
    pidx    = tplb_pkg::LBW'(pxx - base8_s);
    pbit    = {{(LB-1){1'b0}}, 1'b1} << pidx;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r <= '0;
      pv_r <= 1'b0;
    end else begin
      pv_r <= cmd.raw_issue | cmd.lit_step;
      if (cmd.rewind) rp_r <= '0;
      else if (cmd.finish)
        rp_r <= (next_ptr >= GW'(pixmap_bytes)) ? 13'd0 : next_ptr[12:0];
    end
  end

  // Capture the request and walk the row
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      xf_r       <= x_first;
      xl_r       <= xl_c;
      drawing_r  <= draw_enable && (x_first <= xl_c);
      base_idx_r <= 16'(prod + 17'(x_first[8:3]));
      lastk_r    <= xl_c[8:3] - x_first[8:3];
      kout_r     <= '0;
      rem_r      <= '0;
      mcnt_r     <= '0;
    end
    if (cmd.mod_step) begin
      rem_r  <= rem_nxt;
      mcnt_r <= mcnt_r + 4'd1;
    end
    if (cmd.setup) begin
      x_r  <= x_setup;
      te_r <= XW'(x_setup + w_s);
      o_r  <= rem_r;
      g_r  <= GW'(rp_r);
    end
    if (cmd.raw_issue) begin
      px_r   <= x_r;
      psub_r <= o_r[2:0];
      x_r    <= XW'(x_r + 1);
      o_r    <= (o_inc >= {1'b0, w}) ? 13'd0 : o_inc[12:0];
    end
    if (cmd.dec) begin
      hdr_r <= mem_q_r;
      g_r   <= g_r + GW'(1);
      if (mem_q_r[7]) begin
        cnt_r <= dec_n;
      end else begin
        cnt_r <= dec_n - 7'd1;
        x_r   <= XW'(x_r + 1);
      end
    end
    if (cmd.run_step) begin
      x_r   <= XW'(x_r + 1);
      cnt_r <= cnt_r - 7'd1;
    end
    if (cmd.lit_step) begin
      px_r   <= x_r;
      psub_r <= 3'd0;
      x_r    <= XW'(x_r + 1);
      g_r    <= g_r + GW'(1);
      cnt_r  <= cnt_r - 7'd1;
    end
    if (cmd.tile_next) begin
      x_r  <= te_r;
      te_r <= XW'(te_r + w_s);
      g_r  <= GW'(rp_r);
    end
    if (cmd.out_shift) kout_r <= kout_r + 6'd1;
  end

  // Clear, fill and shift out the line buffer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dvec_r <= '0;
      mvec_r <= '0;
    end else if (cmd.out_shift) begin
      dvec_r <= dvec_r >> 8;
      mvec_r <= mvec_r >> 8;
    end else if (hit) begin
      mvec_r <= mvec_r | pbit;
      if (val) dvec_r <= dvec_r | pbit;
    end
  end

  // Status to the controller
  always_comb begin
    sts.mod_last  = (mcnt_r == 4'd11);
    sts.raw_last  = (x_r == xl_s);
    sts.dec_run   = mem_q_r[7];
    sts.lit_one   = (dec_n == 7'd1);
    sts.grp_last  = (cnt_r == 7'd1);
    sts.row_end   = ((x_r + 1) >= te_r);
    sts.tile_more = drawing_r && (te_r <= xl_s);
    sts.drawing   = drawing_r;
    sts.rle       = rle;
    sts.out_last  = (kout_r == lastk_r);
  end

  // Present the current frame byte, leftmost pixel in bit 7
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      fb_data[7-j] = dvec_r[j];
      fb_mask[7-j] = mvec_r[j];
    end
  end

  assign fb_index = base_idx_r + 16'(kout_r);
  assign fb_last  = (kout_r == lastk_r);

endmodule

`default_nettype wire

### src/tiled_pixmap_line_blit_1bpp.sv
// Sequence: a load or rewind request is taken in idle; a draw runs a setup (capture,
// 12-step offset remainder, start), then raw modes walk each span pixel and run-length
// modes walk each tile with a header fetch and decode per run or literal group, then a
// drain step. Results follow at one frame byte per cycle while out_tready is high; the
// controller takes the next request only after the last byte is taken.
// Synchronous active-low reset clears control state and configuration registers; store undefined.
`timescale 1ns / 1ps
`default_nettype none

module tiled_pixmap_line_blit_1bpp #(
  parameter int STORE_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // load_addr[11:0], load_byte[19:12], x_first[28:20], x_last[37:29],
  // row_y[47:38], draw_enable[48], zero fill above
  input  wire logic [55:0] in_tdata,
  // req_type[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // fb_index[15:0], fb_data[23:16], fb_mask[31:24]
  output logic      [31:0] out_tdata,
  output logic             out_tlast
);

  logic [1:0]  mode;
  logic [12:0] pixmap_width, pixmap_bytes;
  logic [8:0]  line_pitch;
  logic [11:0] tile_offset;
  logic [15:0] fb_index;
  logic [7:0]  fb_data, fb_mask;

  tplb_pkg::tplb_cmd_t cmd;
  tplb_pkg::tplb_sts_t sts;

  tplb_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .mode         (mode),
    .pixmap_width (pixmap_width),
    .pixmap_bytes (pixmap_bytes),
    .line_pitch   (line_pitch),
    .tile_offset  (tile_offset)
  );

  tplb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .req_type   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tplb_dp #(
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .mode         (mode),
    .pixmap_width (pixmap_width),
    .pixmap_bytes (pixmap_bytes),
    .line_pitch   (line_pitch),
    .tile_offset  (tile_offset),
    .load_addr    (in_tdata[11:0]),
    .load_byte    (in_tdata[19:12]),
    .x_first      (in_tdata[28:20]),
    .x_last       (in_tdata[37:29]),
    .row_y        (in_tdata[47:38]),
    .draw_enable  (in_tdata[48]),
    .cmd          (cmd),
    .sts          (sts),
    .fb_index     (fb_index),
    .fb_data      (fb_data),
    .fb_mask      (fb_mask),
    .fb_last      (out_tlast)
  );

  assign out_tdata = {fb_mask, fb_data, fb_index};

endmodule

`default_nettype wire

### src/tplb_checker.sv
// Port-level checker for the line blitter and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "tiled_pixmap_line_blit_1bpp_macros.svh"

module tplb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tlast
);

  // No new request is taken while a line is being delivered
  `TPLB_ASSERT_IMP(a_no_overlap, in_tready, !out_tvalid, "request taken during output")
  // A line keeps delivering bytes until its last one
  `TPLB_ASSERT_NXT(a_line_cont, out_tvalid && out_tready && !out_tlast, out_tvalid,
                   "line output stopped early")
  // Frame byte index steps by one within a line
  `TPLB_ASSERT_NXT(a_index_step, out_tvalid && out_tready && !out_tlast,
                   out_tdata[15:0] == $past(out_tdata[15:0]) + 16'd1,
                   "frame byte index not consecutive")
  // After the last byte the block takes requests again
  `TPLB_ASSERT_NXT(a_back_idle, out_tvalid && out_tready && out_tlast, in_tready,
                   "not ready after line end")

endmodule

bind tiled_pixmap_line_blit_1bpp tplb_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

### verif/tiled_pixmap_line_blit_1bpp_tb.sv
// Self-checking testbench for the tiled 1bpp pixelmap line blitter
`timescale 1ns / 1ps

module tiled_pixmap_line_blit_1bpp_tb;

  localparam int STORE_SIZE = 4096;
  localparam int SETTLE_CYCLES = 2000;

  typedef struct {
    logic [1:0]  kind;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [8:0]  xf;
    logic [8:0]  xl;
    logic [9:0]  y;
    logic        en;
  } blit_req_t;

  typedef struct {
    logic [15:0] idx;
    logic [7:0]  data;
    logic [7:0]  mask;
    logic        last;
  } fb_write_t;

  // Line predictor plus queue of expected frame writes
  class blit_scoreboard;
    logic [7:0]  store [STORE_SIZE];
    bit          known [STORE_SIZE];
    int          row_ptr;
    logic [1:0]  mode;
    logic [12:0] width, nbytes;
    logic [8:0]  pitch;
    logic [11:0] offset;
    fb_write_t   fb_expect[$];
    int          errors;
    int          miss_addr;
    int          span_lo, span_hi, span_base;
    logic [7:0]  line_data [64];
    logic [7:0]  line_mask [64];

    function new();
      row_ptr = 0; mode = tplb_pkg::MODE_RAW; width = 1; nbytes = 1; pitch = 480;
      offset = 0;
      errors = 0;
      foreach (known[i]) known[i] = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        tplb_pkg::REG_MODE:   mode = v[1:0];
        tplb_pkg::REG_WIDTH:  width = v[12:0];
        tplb_pkg::REG_BYTES:  nbytes = v[12:0];
        tplb_pkg::REG_PITCH:  pitch = v[8:0];
        tplb_pkg::REG_OFFSET: offset = v[11:0];
        default: ;
      endcase
    endfunction

    // Fetch a pixelmap byte and note the first address never loaded
    function int rd(int a);
      a = a % STORE_SIZE;
      if (!known[a] && miss_addr < 0) miss_addr = a;
      return known[a] ? int'(store[a]) : 0;
    endfunction

    function void put_px(int x, bit opaque, bit val);
      int idx;
      logic [7:0] bitm;
      if (x < span_lo || x > span_hi || !opaque) return;
      idx = ((x >>> 3) - span_base) & 63;
      bitm = 8'h80 >> (x & 7);
      line_mask[idx] |= bitm;
      if (val) line_data[idx] |= bitm;
    endfunction

    // Decode one run-length row starting at column start; return end pointer
    function int rle_row(int start, int w, bit do_put);
      int g, c, n, px, s, x;
      bit plain;
      g = row_ptr;
      plain = (mode == tplb_pkg::MODE_RLE);
      s = plain ? 1 : 2;
      x = start;
      while (x < start + w) begin
        c = rd(g);
        if (c & 8'h80) begin
          n = ((c & 8'h7f) >> s) + 1;
          g++;
          repeat (n) begin
            if (do_put) put_px(x, plain ? 1'b1 : c[0], plain ? c[0] : c[1]);
            x++;
          end
        end else begin
          n = (c >> s) + 1;
          repeat (n) begin
            px = rd(g);
            g++;
            if (do_put) put_px(x, plain ? 1'b1 : px[0], plain ? px[0] : px[1]);
            x++;
          end
        end
      end
      return g;
    endfunction

    function void run_draw(blit_req_t r, bit commit);
      int w, off, xf, xl, lim, nxt, o, x, b, sh, sp, stride, nb;
      bit drawing;
      fb_write_t e;
      w = (width == 0) ? 1 : int'(width);
      off = int'(offset) % w;
      xf = r.xf;
      xl = r.xl;
      if (xl > tplb_pkg::MAX_LINE_PIXELS - 1) xl = tplb_pkg::MAX_LINE_PIXELS - 1;
      lim = (xf & ~7) + tplb_pkg::MAX_RESULTS * 8 - 1;
      if (xl > lim) xl = lim;
      drawing = r.en && xf <= xl;
      span_lo = xf; span_hi = xl; span_base = xf >> 3;
      foreach (line_data[i]) begin
        line_data[i] = 0;
        line_mask[i] = 0;
      end
      if (mode == tplb_pkg::MODE_RAW) begin
        nxt = row_ptr + ((w + 7) >> 3);
        if (drawing) begin
          o = off;
          for (x = xf; x <= xl; x++) begin
            b = rd(row_ptr + (o >> 3));
            put_px(x, 1'b1, (b & (8'h80 >> (o & 7))) != 0);
            o++;
            if (o >= w) o = 0;
          end
        end
      end else if (mode == tplb_pkg::MODE_RAW_T) begin
        nxt = row_ptr + ((w + 3) >> 2);
        if (drawing) begin
          o = off;
          for (x = xf; x <= xl; x++) begin
            sh = (o & 3) << 1;
            b = rd(row_ptr + (o >> 2));
            put_px(x, (b & (8'h40 >> sh)) != 0, (b & (8'h80 >> sh)) != 0);
            o++;
            if (o >= w) o = 0;
          end
        end
      end else if (drawing) begin
        nxt = row_ptr;
        for (sp = xf - off; sp <= xl; sp += w) nxt = rle_row(sp, w, 1'b1);
      end else begin
        nxt = rle_row(0, w, 1'b0);
      end
      if (!commit) return;
      row_ptr = (nxt >= int'(nbytes)) ? 0 : nxt;
      if (!drawing) return;
      stride = (int'(pitch) + 7) >> 3;
      nb = (xl >> 3) - span_base + 1;
      for (int k = 0; k < nb; k++) begin
        e.idx  = 16'(int'(r.y) * stride + span_base + k);
        e.data = line_data[k];
        e.mask = line_mask[k];
        e.last = (k + 1 == nb);
        fb_expect.push_back(e);
      end
    endfunction

    // First unloaded address a draw would fetch, or -1
    function int probe(blit_req_t r);
      miss_addr = -1;
      run_draw(r, 1'b0);
      return miss_addr;
    endfunction

    function void note_request(blit_req_t r);
      case (r.kind)
        tplb_pkg::REQ_LOAD: begin
          store[r.addr] = r.data;
          known[r.addr] = 1;
        end
        tplb_pkg::REQ_DRAW:   run_draw(r, 1'b1);
        tplb_pkg::REQ_REWIND: row_ptr = 0;
        default: ;
      endcase
    endfunction

    function void check_result(logic [31:0] td, logic tl);
      fb_write_t e;
      if (fb_expect.size() == 0) begin
        if (errors < 10) $display("unexpected frame write idx=%h data=%h mask=%h last=%b",
                                  td[15:0], td[23:16], td[31:24], tl);
        errors++;
        return;
      end
      e = fb_expect.pop_front();
      if (td[15:0] !== e.idx || td[23:16] !== e.data || td[31:24] !== e.mask ||
          tl !== e.last) begin
        if (errors < 10)
          $display({"frame write mismatch: expected idx=%h data=%h mask=%h last=%b,",
                    " got idx=%h data=%h mask=%h last=%b"},
                   e.idx, e.data, e.mask, e.last, td[15:0], td[23:16], td[31:24], tl);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;

  blit_scoreboard sb;
  int burst_left = 0;
  int ready_pct = 100;
  int stall_count = 0;

  tiled_pixmap_line_blit_1bpp uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  // Check accepted frame writes and stall on a shifting ready density
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
    stall_count++;
    if (stall_count % 64 == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pct = 100;
        1: ready_pct = 70;
        2: ready_pct = 30;
        default: ready_pct = 5;
      endcase
    end
    out_tready <= ($urandom_range(0, 99) < ready_pct);
  end

  initial begin
    #10ms;
    $display("tiled_pixmap_line_blit_1bpp test failed");
    $finish;
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= 5'(idx) << 2; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  // Drive one request and hold it until accepted
  task automatic push_req(blit_req_t r);
    in_tvalid <= 1'b1;
    in_tuser  <= r.kind;
    in_tdata  <= {7'd0, r.en, r.y, r.xl, r.xf, r.data, r.addr};
    do @(posedge clk); while (!in_tready);
    sb.note_request(r);
    // bursts of random length, sometimes separated by random gaps
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 10);
      if ($urandom_range(0, 1)) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  task automatic load_byte(int a);
    blit_req_t r;
    r = '{kind: tplb_pkg::REQ_LOAD, addr: 12'(a), data: 8'($urandom_range(0, 255)),
          xf: 9'($urandom), xl: 9'($urandom), y: 10'($urandom), en: 1'($urandom)};
    // favor run headers so run-length rows stay short
    if (sb.mode[1] && $urandom_range(0, 3) != 0) r.data[7] = 1'b1;
    push_req(r);
  endtask

  // Fill every byte the draw will fetch, then send it
  task automatic draw_line(int xf, int xl, int y, bit en);
    blit_req_t r;
    int a;
    r = '{kind: tplb_pkg::REQ_DRAW, addr: 12'($urandom), data: 8'($urandom),
          xf: 9'(xf), xl: 9'(xl), y: 10'(y), en: en};
    forever begin
      a = sb.probe(r);
      if (a < 0) break;
      load_byte(a);
    end
    push_req(r);
  endtask

  task automatic plain_req(logic [1:0] kind);
    blit_req_t r;
    r = '{kind: kind, addr: 12'($urandom), data: 8'($urandom),
          xf: 9'($urandom), xl: 9'($urandom), y: 10'($urandom), en: 1'($urandom)};
    push_req(r);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.fb_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_draw();
    int xf, xl;
    xf = $urandom_range(0, 479);
    case ($urandom_range(0, 3))
      0: xl = $urandom_range(0, 511);
      1: begin
        xf = $urandom_range(0, 511);
        xl = $urandom_range(0, 511);
      end
      default: xl = xf + $urandom_range(0, 30);
    endcase
    draw_line(xf, xl > 511 ? 511 : xl, $urandom_range(0, 1023), $urandom_range(0, 9) != 0);
  endtask

  int ph_mode [9]   = '{tplb_pkg::MODE_RAW, tplb_pkg::MODE_RAW_T, tplb_pkg::MODE_RLE,
                        tplb_pkg::MODE_RLE_T, tplb_pkg::MODE_RAW, tplb_pkg::MODE_RAW_T,
                        tplb_pkg::MODE_RLE, tplb_pkg::MODE_RAW, tplb_pkg::MODE_RLE_T};
  int ph_width [9]  = '{16, 13, 9, 12, 4096, 1, 1, 0, 24};
  int ph_bytes [9]  = '{40, 30, 24, 32, 600, 1, 1, 8, 20};
  int ph_pitch [9]  = '{480, 200, 1, 479, 480, 64, 100, 480, 33};
  int ph_offset [9] = '{3, 4095, 0, 7, 4095, 0, 5, 9, 2048};

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed lines at the reset settings
    draw_line(0, 479, 0, 1'b1);
    draw_line(0, 0, 1023, 1'b1);
    draw_line(7, 8, 5, 1'b1);
    draw_line(479, 511, 3, 1'b1);
    draw_line(511, 511, 2, 1'b1);
    draw_line(9, 3, 4, 1'b1);
    draw_line(0, 100, 6, 1'b0);
    plain_req(tplb_pkg::REQ_REWIND);
    plain_req(2'd3);
    draw_line(1, 479, 1022, 1'b1);
    wait_idle();
    // register beyond the last index is ignored
    cfg_write(3'd5, 32'hffff_ffff);

    for (int p = 0; p < 9; p++) begin
      cfg_write(tplb_pkg::REG_MODE, ph_mode[p]);
      cfg_write(tplb_pkg::REG_WIDTH, ph_width[p]);
      cfg_write(tplb_pkg::REG_BYTES, ph_bytes[p]);
      cfg_write(tplb_pkg::REG_PITCH, ph_pitch[p]);
      cfg_write(tplb_pkg::REG_OFFSET, ph_offset[p]);
      plain_req(tplb_pkg::REQ_REWIND);
      for (int i = 0; i < 8; i++) begin
        case ($urandom_range(0, 9))
          0: plain_req(tplb_pkg::REQ_REWIND);
          1: load_byte($urandom_range(0, 4095));
          2: plain_req(2'd3);
          default: random_draw();
        endcase
        // hold off until the block has drained once
        if (p == 3 && i == 4) wait_idle();
      end
      wait_idle();
    end

    in_tvalid <= 1'b0;
    if (sb.errors == 0 && sb.fb_expect.size() == 0)
      $display("tiled_pixmap_line_blit_1bpp test passed");
    else
      $display("tiled_pixmap_line_blit_1bpp test failed");
    $finish;
  end

endmodule
